// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold on every clock edge out of reset
`define SMR_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define SMR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("%m");

// cons must hold in the cycle after ante
`define SMR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("%m");

`endif

// ===== rtl/smr_pkg.sv =====
package smr_pkg;

  localparam int SMR_STORE_DEPTH = 2048;

  localparam int COUNT_W   = 16;
  localparam int PULSE_W   = 11;
  localparam int ADC_W     = 12;
  localparam int RECLEN_W  = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_US     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_LOW       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_HIGH      = 2'd3;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_SAMPLE = 2'd1;
  localparam logic [1:0] ACT_BUTTON = 2'd2;

  localparam logic [COUNT_W-1:0]  PERIOD_RST   = 16'd20000;
  localparam logic [RECLEN_W-1:0] RECLEN_RST   = 12'd2000;
  localparam logic [ADC_W-1:0]    ADC_LOW_RST  = 12'd100;
  localparam logic [ADC_W-1:0]    ADC_HIGH_RST = 12'd4000;
  localparam logic [ADC_W-1:0]    ADC_FULL     = 12'd4095;
  localparam logic [PULSE_W-1:0]  PULSE_RST    = 11'd1500;
  localparam logic [PULSE_W-1:0]  PULSE_MIN    = 11'd1000;
  localparam logic [PULSE_W-1:0]  PULSE_MAX    = 11'd2000;
  localparam logic [9:0]          ADC_SCALE    = 10'd1000;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;
  localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_TICK,
    OP_SAMPLE,
    OP_BUTTON,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    MODE_MANUAL = 2'd0,
    MODE_RECORD = 2'd1,
    MODE_PLAY   = 2'd2
  } mode_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  period_us;
    logic [RECLEN_W-1:0] record_length;
    logic [ADC_W-1:0]    adc_low;
    logic [ADC_W-1:0]    adc_high;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [PULSE_W-1:0] pulse;
  } mid_item_t;

  typedef struct packed {
    logic               servo_level;
    logic [PULSE_W-1:0] pulse_width;
    logic [1:0]         mode;
    logic               rec_led;
    logic               frame_start;
    logic               record_full;
  } result_t;

endpackage

// ===== rtl/smr_ram.sv =====
module smr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/smr_fifo.sv =====
`include "assert_macros.svh"

module smr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  `SMR_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(DEPTH), "fifo count overflow")
  `SMR_ASSERT_IMPLIES(a_no_push_full, clk, rst, push, !full)

endmodule

// ===== rtl/smr_front.sv =====
module smr_front import smr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [1:0]           action,
  input  logic [ADC_W-1:0]     adc_value,
  input  cfg_t                 cfg,
  input  logic [MID_CNT_W-1:0] q_count,
  output logic                 full,
  output logic                 q_push,
  output mid_item_t            q_item
);

  // adc * 1000 needs 22 bits; quotient by 4095 fits 10 bits
  localparam int X_W = ADC_W + 10;
  localparam int E_W = X_W - ADC_W;

  logic               v1;
  logic               v2;
  op_t                op_in;
  op_t                op1;
  op_t                op2;
  logic               below1;
  logic               above1;
  logic               below2;
  logic               above2;
  logic [X_W-1:0]     x1;
  logic [X_W-1:0]     x2;
  logic [E_W-1:0]     e2;
  logic [X_W-1:0]     est_sum;
  logic [X_W-1:0]     prod;
  logic [X_W-1:0]     rem;
  logic               inc;
  logic [PULSE_W-1:0] pulse;
  logic [MID_CNT_W:0] credit;

  // in-flight items reserve queue slots
  assign credit = {1'b0, q_count} + (MID_CNT_W+1)'(v1) + (MID_CNT_W+1)'(v2);
  assign full   = (credit >= (MID_CNT_W+1)'(MID_DEPTH));

  always_comb begin
    case (action)
      ACT_TICK:   op_in = OP_TICK;
      ACT_SAMPLE: op_in = OP_SAMPLE;
      ACT_BUTTON: op_in = OP_BUTTON;
      default:    op_in = OP_NOP;
    endcase
  end

  // x/4095 estimate via x*4097/2^24, low by at most one
  assign est_sum = x1 + (x1 >> ADC_W);
  assign prod    = {e2, {ADC_W{1'b0}}} - X_W'(e2);
  assign rem     = x2 - prod;
  assign inc     = (rem >= X_W'(ADC_FULL));

  always_comb begin
    if (below2) begin
      pulse = PULSE_MIN;
    end else if (above2) begin
      pulse = PULSE_MAX;
    end else begin
      pulse = PULSE_MIN + PULSE_W'(e2) + PULSE_W'(inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= push && !full;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    op1    <= op_in;
    below1 <= (adc_value < cfg.adc_low);
    above1 <= (adc_value > cfg.adc_high);
    x1     <= X_W'(adc_value) * X_W'(ADC_SCALE);
    op2    <= op1;
    below2 <= below1;
    above2 <= above1;
    x2     <= x1;
    e2     <= est_sum[X_W-1 -: E_W];
  end

  assign q_push       = v2;
  assign q_item.op    = op2;
  assign q_item.pulse = pulse;

endmodule

// ===== rtl/smr_back.sv =====
`include "assert_macros.svh"

module smr_back import smr_pkg::*; #(
  parameter int STORE_DEPTH = SMR_STORE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  mid_item_t q_item,
  output logic      q_pop,
  input  logic      out_full,
  output logic      out_push,
  output result_t   out_item
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int LW = AW + 1;

  mode_t              mode;
  mode_t              mode_next;
  logic [COUNT_W-1:0] counter;
  logic [COUNT_W-1:0] counter_next;
  logic [PULSE_W-1:0] active;
  logic [PULSE_W-1:0] active_next;
  logic [PULSE_W-1:0] latest;
  logic [PULSE_W-1:0] latest_next;
  logic [LW-1:0]      widx;
  logic [LW-1:0]      widx_next;
  logic [AW-1:0]      ridx;
  logic [AW-1:0]      ridx_next;
  logic [LW-1:0]      hwm;
  logic [LW-1:0]      hwm_next;

  logic               fire;
  logic [31:0]        len_wide;
  logic [LW-1:0]      len;
  logic [COUNT_W-1:0] per;
  logic [COUNT_W:0]   cnt_inc;
  logic               wrap;
  logic               wrapped;
  logic [AW-1:0]      rd_idx;
  logic [LW-1:0]      rd_next1;
  logic [LW-1:0]      widx_inc;
  logic [PULSE_W-1:0] stored;
  logic [PULSE_W-1:0] rdata;
  logic [AW-1:0]      raddr;
  logic               we;

  assign fire     = q_valid && !out_full;
  assign q_pop    = fire;
  assign out_push = fire;

  assign len_wide = (cfg.record_length == '0) ? 32'd1 :
                    (32'(cfg.record_length) > 32'(STORE_DEPTH)) ? 32'(STORE_DEPTH) :
                    32'(cfg.record_length);
  assign len      = len_wide[LW-1:0];

  assign per      = (cfg.period_us == '0) ? COUNT_W'(1) : cfg.period_us;
  assign cnt_inc  = (COUNT_W+1)'(counter) + (COUNT_W+1)'(1);
  assign wrap     = (cnt_inc >= {1'b0, per});

  assign rd_idx   = ({1'b0, ridx} >= len) ? '0 : ridx;
  assign rd_next1 = {1'b0, rd_idx} + LW'(1);
  assign widx_inc = widx + LW'(1);
  // entries at or above the fill mark were never written: read as zero
  assign stored   = ({1'b0, rd_idx} < hwm) ? rdata : '0;

  always_comb begin
    mode_next    = mode;
    counter_next = counter;
    active_next  = active;
    latest_next  = latest;
    widx_next    = widx;
    ridx_next    = ridx;
    hwm_next     = hwm;
    wrapped      = 1'b0;
    we           = 1'b0;
    if (fire) begin
      case (q_item.op)
        OP_TICK: begin
          counter_next = wrap ? '0 : cnt_inc[COUNT_W-1:0];
          wrapped      = wrap;
          if (wrap && mode == MODE_RECORD && widx < len) begin
            we        = 1'b1;
            widx_next = widx_inc;
            hwm_next  = (widx_inc > hwm) ? widx_inc : hwm;
          end
          if (wrap && mode == MODE_PLAY) begin
            active_next = stored;
            ridx_next   = (rd_next1 >= len) ? '0 : rd_next1[AW-1:0];
          end
        end
        OP_SAMPLE: begin
          if (mode != MODE_PLAY) begin
            latest_next = q_item.pulse;
            active_next = q_item.pulse;
          end
        end
        OP_BUTTON: begin
          case (mode)
            MODE_MANUAL: mode_next = MODE_RECORD;
            MODE_RECORD: mode_next = MODE_PLAY;
            MODE_PLAY:   mode_next = MODE_MANUAL;
            default:     mode_next = MODE_MANUAL;
          endcase
          widx_next = '0;
          ridx_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // prefetch the entry the next play frame will load
  assign raddr = ({1'b0, ridx_next} >= len) ? '0 : ridx_next;

  smr_ram #(
    .WIDTH (PULSE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (widx[AW-1:0]),
    .wdata (latest),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_MANUAL;
    end else begin
      mode <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      active  <= PULSE_RST;
      latest  <= PULSE_RST;
      widx    <= '0;
      ridx    <= '0;
      hwm     <= '0;
    end else begin
      counter <= counter_next;
      active  <= active_next;
      latest  <= latest_next;
      widx    <= widx_next;
      ridx    <= ridx_next;
      hwm     <= hwm_next;
    end
  end

  assign out_item.servo_level = (counter_next < COUNT_W'(active_next));
  assign out_item.pulse_width = active_next;
  assign out_item.mode        = mode_next;
  assign out_item.rec_led     = (mode_next == MODE_RECORD);
  assign out_item.frame_start = wrapped;
  assign out_item.record_full = (widx_next >= len);

  `SMR_ASSERT_ALWAYS(a_widx_in_fill, clk, rst, widx <= hwm, "write index past fill mark")
  `SMR_ASSERT_NEXT(a_button_clears, clk, rst, fire && q_item.op == OP_BUTTON,
                   widx == '0 && ridx == '0)

endmodule

// ===== rtl/servo_motion_recorder_core.sv =====
// Servo pulse recorder.
// Input channel: push/full with action and adc_value. A transfer happens when
// push is high and full is low. action 0 is a microsecond tick, 1 an ADC
// sample, 2 a button press; any other code only reports status.
// Result channel: empty/pop. One result per input transfer, in order; the
// oldest result sits on the result ports while empty is low.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while no items are in flight.
// Path: an input transfer passes two front stages for the sample scaling, is
// written into the command queue, then the back execute writes its result
// into the result queue.
// Throughput: one item per cycle while the result queue has room, with the back
// execute using a prefetched read of the pulse store.
// When pop stalls, the 2-entry result queue fills, the back end holds, the
// 4-entry command queue fills and full rises; nothing is dropped.
// Reset (rst, synchronous): config registers to defaults, manual mode,
// counter zero, pulses 1500, indexes and fill mark zero. The store needs no
// clearing pass: entries beyond the fill mark read as zero.
module servo_motion_recorder_core import smr_pkg::*; #(
  parameter int STORE_DEPTH = SMR_STORE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            action,
  input  logic [ADC_W-1:0]      adc_value,
  output logic                  empty,
  input  logic                  pop,
  output logic                  servo_level,
  output logic [PULSE_W-1:0]    pulse_width,
  output logic [1:0]            mode,
  output logic                  rec_led,
  output logic                  frame_start,
  output logic                  record_full,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                 cfg;
  logic                 mid_push;
  mid_item_t            mid_wdata;
  mid_item_t            mid_rdata;
  logic                 mid_pop;
  logic                 mid_empty;
  logic                 mid_full;
  logic [MID_CNT_W-1:0] mid_count;
  logic                 out_push;
  result_t              out_wdata;
  result_t              out_rdata;
  logic                 out_full;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_us     <= PERIOD_RST;
      cfg.record_length <= RECLEN_RST;
      cfg.adc_low       <= ADC_LOW_RST;
      cfg.adc_high      <= ADC_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PERIOD_US:     cfg.period_us     <= cfg_data;
        REG_RECORD_LENGTH: cfg.record_length <= cfg_data[RECLEN_W-1:0];
        REG_ADC_LOW:       cfg.adc_low       <= cfg_data[ADC_W-1:0];
        REG_ADC_HIGH:      cfg.adc_high      <= cfg_data[ADC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  smr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .action    (action),
    .adc_value (adc_value),
    .cfg       (cfg),
    .q_count   (mid_count),
    .full      (full),
    .q_push    (mid_push),
    .q_item    (mid_wdata)
  );

  smr_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wdata),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .full  (mid_full),
    .empty (mid_empty),
    .count (mid_count)
  );

  smr_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (!mid_empty),
    .q_item   (mid_rdata),
    .q_pop    (mid_pop),
    .out_full (out_full),
    .out_push (out_push),
    .out_item (out_wdata)
  );

  smr_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wdata),
    .pop   (pop),
    .rdata (out_rdata),
    .full  (out_full),
    .empty (empty),
    .count (out_count)
  );

  assign servo_level = out_rdata.servo_level;
  assign pulse_width = out_rdata.pulse_width;
  assign mode        = out_rdata.mode;
  assign rec_led     = out_rdata.rec_led;
  assign frame_start = out_rdata.frame_start;
  assign record_full = out_rdata.record_full;

  `SMR_ASSERT_IMPLIES(a_mid_room, clk, rst, mid_push, !mid_full)
  `SMR_ASSERT_IMPLIES(a_out_empty, clk, rst, empty, out_count == '0)

endmodule

// ===== test/tb_servo_motion_recorder_core.sv =====
`timescale 1ns / 1ps

module tb_servo_motion_recorder_core;
  import smr_pkg::*;

  localparam logic [1:0] ACT_STATUS = OP_NOP;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic [1:0] action;
  logic [ADC_W-1:0] adc_value;
  logic empty;
  logic pop;
  logic servo_level;
  logic [PULSE_W-1:0] pulse_width;
  logic [1:0] mode;
  logic rec_led;
  logic frame_start;
  logic record_full;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  servo_motion_recorder_core DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .action(action),
    .adc_value(adc_value),
    .empty(empty),
    .pop(pop),
    .servo_level(servo_level),
    .pulse_width(pulse_width),
    .mode(mode),
    .rec_led(rec_led),
    .frame_start(frame_start),
    .record_full(record_full),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor state
  logic [COUNT_W-1:0] period_cfg;
  logic [RECLEN_W-1:0] reclen_cfg;
  logic [ADC_W-1:0] adc_low_cfg;
  logic [ADC_W-1:0] adc_high_cfg;
  mode_t cur_mode;
  int tick_count;
  logic [PULSE_W-1:0] live_pulse;
  logic [PULSE_W-1:0] sample_pulse;
  logic [PULSE_W-1:0] pulse_mem [SMR_STORE_DEPTH];
  int wr_idx;
  int rd_idx;

  result_t status_expect_q[$];
  int mismatches;
  int idle_en;
  int hold_request;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic int frames_in_loop();
    int n;
    n = reclen_cfg;
    if (n == 0) n = 1;
    if (n > SMR_STORE_DEPTH) n = SMR_STORE_DEPTH;
    return n;
  endfunction

  function automatic logic [PULSE_W-1:0] sample_to_pulse(logic [ADC_W-1:0] val);
    if (val < adc_low_cfg) return PULSE_MIN;
    if (val > adc_high_cfg) return PULSE_MAX;
    return PULSE_W'(int'(PULSE_MIN) + int'(val) * int'(ADC_SCALE) / int'(ADC_FULL));
  endfunction

  function automatic result_t predict_servo_status(logic [1:0] act, logic [ADC_W-1:0] val);
    result_t res;
    int len;
    int per;
    logic wrapped;
    len = frames_in_loop();
    wrapped = 1'b0;
    case (act)
      ACT_TICK: begin
        per = (period_cfg == 0) ? 1 : int'(period_cfg);
        if (tick_count + 1 >= per) begin
          tick_count = 0;
          wrapped = 1'b1;
        end else begin
          tick_count++;
        end
        if (wrapped && cur_mode == MODE_RECORD) begin
          if (wr_idx < len) begin
            pulse_mem[wr_idx] = sample_pulse;
            wr_idx++;
          end
        end else if (wrapped && cur_mode == MODE_PLAY) begin
          if (rd_idx >= len) rd_idx = 0;
          live_pulse = pulse_mem[rd_idx];
          rd_idx++;
          if (rd_idx >= len) rd_idx = 0;
        end
      end
      ACT_SAMPLE: begin
        if (cur_mode != MODE_PLAY) begin
          sample_pulse = sample_to_pulse(val);
          live_pulse = sample_pulse;
        end
      end
      ACT_BUTTON: begin
        case (cur_mode)
          MODE_MANUAL: cur_mode = MODE_RECORD;
          MODE_RECORD: cur_mode = MODE_PLAY;
          default: cur_mode = MODE_MANUAL;
        endcase
        wr_idx = 0;
        rd_idx = 0;
      end
      default: ;
    endcase
    res.servo_level = (tick_count < int'(live_pulse));
    res.pulse_width = live_pulse;
    res.mode = cur_mode;
    res.rec_led = (cur_mode == MODE_RECORD);
    res.frame_start = wrapped;
    res.record_full = (wr_idx >= len);
    return res;
  endfunction

  function automatic logic [1:0] rand_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return ACT_TICK;
    if (r < 85) return ACT_SAMPLE;
    if (r < 95) return ACT_BUTTON;
    return ACT_STATUS;
  endfunction

  function automatic logic [ADC_W-1:0] rand_adc();
    case ($urandom_range(0, 5))
      0: return adc_low_cfg - 1'b1;
      1: return adc_low_cfg;
      2: return adc_high_cfg;
      3: return adc_high_cfg + 1'b1;
      default: return ADC_W'($urandom);
    endcase
  endfunction

  function automatic int rand_period();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      default: return $urandom_range(2, 4);
    endcase
  endfunction

  function automatic int rand_reclen();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return $urandom_range(2049, 4095);
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  // Leaves push high after the transfer so back-to-back items need no re-raise.
  task automatic send_item(logic [1:0] act, logic [ADC_W-1:0] val);
    if (idle_en != 0 && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push <= 1'b1;
    action <= act;
    adc_value <= val;
    @(posedge clk);
    while (full) @(posedge clk);
    status_expect_q.push_back(predict_servo_status(act, val));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PERIOD_US: period_cfg = val;
      REG_RECORD_LENGTH: reclen_cfg = val[RECLEN_W-1:0];
      REG_ADC_LOW: adc_low_cfg = val[ADC_W-1:0];
      default: adc_high_cfg = val[ADC_W-1:0];
    endcase
    @(posedge clk);
  endtask

  // Registers change only with the pipeline drained.
  task automatic set_config(int per, int len, int lo, int hi);
    push <= 1'b0;
    while (status_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_PERIOD_US, CFG_DATA_W'(per));
    write_reg(REG_RECORD_LENGTH, {4'($urandom), 12'(len)});
    write_reg(REG_ADC_LOW, {4'($urandom), 12'(lo)});
    write_reg(REG_ADC_HIGH, {4'($urandom), 12'(hi)});
  endtask

  task automatic goto_mode(mode_t target);
    while (cur_mode != target) send_item(ACT_BUTTON, ADC_W'($urandom));
  endtask

  task automatic send_frame_ticks();
    int t;
    int per;
    per = (period_cfg == 0) ? 1 : int'(period_cfg);
    for (t = 0; t < per; t++) send_item(ACT_TICK, ADC_W'($urandom));
  endtask

  task automatic test_sample_mapping();
    send_item(ACT_SAMPLE, 12'd0);
    send_item(ACT_SAMPLE, 12'd99);
    send_item(ACT_SAMPLE, 12'd100);
    send_item(ACT_SAMPLE, 12'd2047);
    send_item(ACT_SAMPLE, 12'd4001);
    send_item(ACT_SAMPLE, 12'd4000);
    send_item(ACT_STATUS, 12'hFFF);
    send_item(ACT_TICK, 12'hABC);
  endtask

  task automatic test_mode_cycle();
    send_item(ACT_BUTTON, 12'd0);
    send_item(ACT_SAMPLE, 12'd3000);
    send_item(ACT_TICK, 12'd0);
    send_item(ACT_BUTTON, 12'd0);
    send_item(ACT_SAMPLE, 12'd500);
    send_item(ACT_TICK, 12'd0);
    send_item(ACT_BUTTON, 12'd0);
  endtask

  task automatic test_config_extremes();
    // zero period and zero length, thresholds crossed
    set_config(0, 0, 4095, 0);
    send_item(ACT_SAMPLE, 12'd4095);
    send_item(ACT_SAMPLE, 12'd0);
    goto_mode(MODE_RECORD);
    send_item(ACT_TICK, 12'd0);
    send_item(ACT_TICK, 12'd0);
    goto_mode(MODE_PLAY);
    send_item(ACT_TICK, 12'd0);
    send_item(ACT_TICK, 12'd0);
    goto_mode(MODE_MANUAL);
    set_config(65535, 2048, 0, 4095);
    send_item(ACT_SAMPLE, 12'd0);
    send_item(ACT_SAMPLE, 12'd4095);
    send_item(ACT_TICK, 12'd0);
  endtask

  task automatic test_record_playback();
    int s;
    int f;
    int frames;
    for (s = 0; s < 10; s++) begin
      if ($urandom_range(0, 3) == 0)
        set_config(rand_period(), rand_reclen(), $urandom_range(0, 4095),
                   $urandom_range(0, 4095));
      else
        set_config(rand_period(), rand_reclen(), $urandom_range(0, 300),
                   $urandom_range(3700, 4095));
      goto_mode(MODE_RECORD);
      frames = frames_in_loop();
      if (frames > 4) frames = 4;
      for (f = 0; f < frames + 1; f++) begin
        send_item(ACT_SAMPLE, rand_adc());
        if ($urandom_range(0, 5) == 0) send_item(ACT_STATUS, ADC_W'($urandom));
        send_frame_ticks();
      end
      goto_mode(MODE_PLAY);
      for (f = 0; f < 2 * frames + 1; f++) begin
        if ($urandom_range(0, 3) == 0) send_item(ACT_SAMPLE, rand_adc());
        send_frame_ticks();
      end
      goto_mode(MODE_MANUAL);
      send_item(ACT_SAMPLE, rand_adc());
      send_item(ACT_TICK, ADC_W'($urandom));
    end
  endtask

  task automatic test_backpressure();
    int i;
    set_config($urandom_range(2, 5), $urandom_range(1, 8), 100, 4000);
    hold_request = 60;
    for (i = 0; i < 40; i++) send_item(rand_action(), rand_adc());
  endtask

  task automatic test_random_mix();
    int i;
    set_config(rand_period(), rand_reclen(), $urandom_range(0, 4095),
               $urandom_range(0, 4095));
    for (i = 0; i < 530; i++) begin
      if (i == 380) idle_en = 0;
      send_item(rand_action(), rand_adc());
    end
  endtask

  initial begin : status_checker
    int stall_left;
    int hold_left;
    result_t got;
    result_t want;
    stall_left = 0;
    hold_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got = {servo_level, pulse_width, mode, rec_led, frame_start, record_full};
        if (status_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transfer at cycle %0d", cycle_count);
        end else begin
          want = status_expect_q.pop_front();
          if (got.servo_level !== want.servo_level || got.pulse_width !== want.pulse_width ||
              got.mode !== want.mode || got.rec_led !== want.rec_led ||
              got.frame_start !== want.frame_start ||
              got.record_full !== want.record_full) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch at cycle %0d: expected lvl=%0b pw=%0d mode=%0d led=%0b",
                        " frame=%0b full=%0b, got lvl=%0b pw=%0d mode=%0d led=%0b",
                        " frame=%0b full=%0b"},
                       cycle_count, want.servo_level, want.pulse_width, want.mode,
                       want.rec_led, want.frame_start, want.record_full,
                       got.servo_level, got.pulse_width, got.mode,
                       got.rec_led, got.frame_start, got.record_full);
          end
        end
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (idle_en != 0 && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : main_seq
    int i;
    rst <= 1'b1;
    push <= 1'b0;
    action <= ACT_TICK;
    adc_value <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_PERIOD_US;
    cfg_data <= '0;
    mismatches = 0;
    idle_en = 1;
    hold_request = 0;
    period_cfg = PERIOD_RST;
    reclen_cfg = RECLEN_RST;
    adc_low_cfg = ADC_LOW_RST;
    adc_high_cfg = ADC_HIGH_RST;
    cur_mode = MODE_MANUAL;
    tick_count = 0;
    live_pulse = PULSE_RST;
    sample_pulse = PULSE_RST;
    wr_idx = 0;
    rd_idx = 0;
    for (i = 0; i < SMR_STORE_DEPTH; i++) pulse_mem[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_sample_mapping();
    test_mode_cycle();
    test_config_extremes();
    test_record_playback();
    test_backpressure();
    test_random_mix();

    push <= 1'b0;
    while (status_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
